FILE: rtl/rpe_pkg.sv
package rpe_pkg;

  localparam int CordicStages = 24;
  localparam int TableDepth   = 64;
  localparam int AtanEntries  = 32;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpRotate = 1'b1;

  // 2*pi in Q.32 and the Q3.30 fold limits
  localparam logic [34:0] TwoPiQ32   = 35'd26986075409;
  localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;
  localparam logic signed [32:0] GainInv   = 33'sh026DD3B6A;

  // reciprocal of 2*pi*2^32, scaled by 2^54, for the quotient estimate
  localparam logic [63:0] RecipFull = (64'd1 << 54) / 64'd26986075409;
  localparam logic [19:0] Recip     = RecipFull[19:0];

  typedef struct packed {
    logic               operation;
    logic [5:0]         pair_index;
    logic [11:0]        position;
    logic [31:0]        freq_value;
    logic signed [31:0] element_low;
    logic signed [31:0] element_high;
  } rpe_in_t;

  typedef struct packed {
    logic signed [31:0] rotated_low;
    logic signed [31:0] rotated_high;
    logic               saturated;
  } rpe_out_t;

  typedef struct packed {
    logic               valid;
    logic               neg;
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } cordic_t;

  function automatic logic signed [32:0] atan_q30(input int idx);
    logic signed [32:0] v;
    v = '0;
    case (idx)
      0:  v = 33'sh03243F6A8;
      1:  v = 33'sh01DAC6705;
      2:  v = 33'sh00FADBAFC;
      3:  v = 33'sh007F56EA6;
      4:  v = 33'sh003FEAB76;
      5:  v = 33'sh001FFD55B;
      6:  v = 33'sh000FFFAAA;
      7:  v = 33'sh0007FFF55;
      8:  v = 33'sh0003FFFEA;
      9:  v = 33'sh0001FFFFD;
      10: v = 33'sh0000FFFFF;
      11: v = 33'sh00007FFFF;
      12: v = 33'sh00003FFFF;
      13: v = 33'sh00001FFFF;
      14: v = 33'sh00000FFFF;
      15: v = 33'sh000007FFF;
      16: v = 33'sh000003FFF;
      17: v = 33'sh000001FFF;
      18: v = 33'sh000000FFF;
      19: v = 33'sh0000007FF;
      20: v = 33'sh0000003FF;
      21: v = 33'sh0000001FF;
      22: v = 33'sh0000000FF;
      23: v = 33'sh00000007F;
      24: v = 33'sh00000003F;
      25: v = 33'sh00000001F;
      26: v = 33'sh00000000F;
      27: v = 33'sh000000008;
      28: v = 33'sh000000004;
      29: v = 33'sh000000002;
      30: v = 33'sh000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/rpe_ram.sv
module rpe_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rpe_cordic_cell.sv
module rpe_cordic_cell #(
  parameter int Shift = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  rpe_pkg::cordic_t  cell_i,
  output rpe_pkg::cordic_t  cell_o
);
  import rpe_pkg::*;

  cordic_t cell_d, cell_q;
  logic signed [32:0] xs, ys, at;

  always_comb begin
    xs = cell_i.x >>> Shift;
    ys = cell_i.y >>> Shift;
    at = atan_q30(Shift);
    cell_d = cell_i;
    if (!cell_i.z[32]) begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - at;
    end else begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

FILE: rtl/rotary_position_embedding_core.sv
// Half-split rotary position embedding. A load beat (operation 0) writes one
// inverse frequency (unsigned Q0.32) into the 64-entry table at pair_index and
// gives no result. A rotate beat (operation 1) turns the pair (element_low,
// element_high), both signed Q16.16, by position * freq[pair_index], and gives
// one result beat with both rotated values rounded half up, saturated to 32
// bits and flagged. Rotating with a table entry never loaded gives undefined
// values. One beat is taken per cycle while no result beat waits at the output;
// a rotate result passes through the angle reduction stages, the row of CORDIC
// cells and the multiply stages, all registered. The whole pipe holds while a
// result beat waits at the output, so in_ready_o drops only then. A load
// followed by a rotate on the same entry sees the new value.
module rotary_position_embedding_core #(
  parameter int CORDIC_STAGES = rpe_pkg::CordicStages
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rpe_pkg::rpe_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rpe_pkg::rpe_out_t out_data_o
);
  import rpe_pkg::*;

  logic en, accept;
  logic [31:0] freq_rd;

  // stage valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, m1_q, m2_q, out_valid_q;

  // payload carried alongside
  logic signed [31:0] lo1_q, hi1_q, lo2_q, hi2_q, lo3_q, hi3_q;
  logic signed [31:0] lo4_q, hi4_q, lo5_q, hi5_q, lo6_q, hi6_q;
  logic [11:0] pos1_q;
  logic [43:0] angle2_q, angle3_q, angle4_q;
  logic [9:0]  quot3_q;
  logic [43:0] prod4_q;
  logic [34:0] rem5_q;
  logic signed [32:0] z6_q;
  logic neg6_q;

  logic [39:0] quot_full;
  logic [44:0] prod_full;
  logic [43:0] rem_raw;
  logic [34:0] rem_d;
  logic [35:0] rnd_sum;
  logic signed [35:0] z_a, z_b;
  logic neg_d;

  logic signed [31:0] cos_q, sin_q, lo_m1_q, hi_m1_q;
  logic signed [63:0] lc_q, hs_q, hc_q, ls_q;
  logic signed [64:0] sum_lo, sum_hi;
  logic signed [34:0] sh_lo, sh_hi;
  logic signed [31:0] res_lo, res_hi;
  logic sat_lo, sat_hi;
  rpe_out_t out_data_q;

  cordic_t chain [CORDIC_STAGES+1];

  // stall everything while the output beat is not taken
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  rpe_ram #(
    .Width(32),
    .Depth(TableDepth)
  ) u_freq_ram (
    .clk_i  (clk_i),
    .we_i   (accept && (in_data_i.operation == OpLoad)),
    .waddr_i(in_data_i.pair_index),
    .wdata_i(in_data_i.freq_value),
    .re_i   (en),
    .raddr_i(in_data_i.pair_index),
    .rdata_o(freq_rd)
  );

  // angle reduction: quotient estimate by reciprocal, then one correction
  always_comb begin
    quot_full = angle2_q[43:24] * Recip;
    prod_full = {35'd0, quot3_q} * {10'd0, TwoPiQ32};
    rem_raw   = angle4_q - prod4_q;
    rem_d     = (rem_raw >= {9'd0, TwoPiQ32}) ? rem_raw[34:0] - TwoPiQ32 : rem_raw[34:0];
    rnd_sum   = {1'b0, rem5_q} + 36'd2;
    z_a       = $signed({2'b00, rnd_sum[35:2]});
    if (z_a > PiQ30) begin
      z_a = z_a - TwoPiQ30;
    end
    neg_d = 1'b0;
    z_b   = z_a;
    if (z_a > HalfPiQ30) begin
      z_b   = z_a - PiQ30;
      neg_d = 1'b1;
    end else if (z_a < -HalfPiQ30) begin
      z_b   = z_a + PiQ30;
      neg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept && (in_data_i.operation == OpRotate);
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos1_q   <= in_data_i.position;
      lo1_q    <= in_data_i.element_low;
      hi1_q    <= in_data_i.element_high;
      angle2_q <= {20'd0, pos1_q} * {12'd0, freq_rd};
      lo2_q    <= lo1_q;
      hi2_q    <= hi1_q;
      quot3_q  <= quot_full[39:30];
      angle3_q <= angle2_q;
      lo3_q    <= lo2_q;
      hi3_q    <= hi2_q;
      prod4_q  <= prod_full[43:0];
      angle4_q <= angle3_q;
      lo4_q    <= lo3_q;
      hi4_q    <= hi3_q;
      rem5_q   <= rem_d;
      lo5_q    <= lo4_q;
      hi5_q    <= hi4_q;
      z6_q     <= z_b[32:0];
      neg6_q   <= neg_d;
      lo6_q    <= lo5_q;
      hi6_q    <= hi5_q;
    end
  end

  // row of CORDIC cells, one micro-rotation each
  assign chain[0] = '{valid: v6_q, neg: neg6_q, x: GainInv, y: '0, z: z6_q,
                      lo: lo6_q, hi: hi6_q};

  for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cell
    rpe_cordic_cell #(
      .Shift(gi)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .cell_i(chain[gi]),
      .cell_o(chain[gi+1])
    );
  end

  // output arithmetic: products exact, then round half up and clamp
  always_comb begin
    sum_lo = 65'(lc_q) - 65'(hs_q) + 65'sd536870912;
    sum_hi = 65'(hc_q) + 65'(ls_q) + 65'sd536870912;
    sh_lo  = 35'(sum_lo >>> 30);
    sh_hi  = 35'(sum_hi >>> 30);
    sat_lo = (sh_lo > 35'sd2147483647) || (sh_lo < -35'sd2147483648);
    sat_hi = (sh_hi > 35'sd2147483647) || (sh_hi < -35'sd2147483648);
    res_lo = sat_lo ? (sh_lo[34] ? 32'sh80000000 : 32'sh7FFFFFFF) : sh_lo[31:0];
    res_hi = sat_hi ? (sh_hi[34] ? 32'sh80000000 : 32'sh7FFFFFFF) : sh_hi[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q        <= 1'b0;
      m2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      m1_q        <= chain[CORDIC_STAGES].valid;
      m2_q        <= m1_q;
      out_valid_q <= m2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cos_q   <= chain[CORDIC_STAGES].neg ? 32'(-chain[CORDIC_STAGES].x)
                                          : chain[CORDIC_STAGES].x[31:0];
      sin_q   <= chain[CORDIC_STAGES].neg ? 32'(-chain[CORDIC_STAGES].y)
                                          : chain[CORDIC_STAGES].y[31:0];
      lo_m1_q <= chain[CORDIC_STAGES].lo;
      hi_m1_q <= chain[CORDIC_STAGES].hi;
      lc_q    <= lo_m1_q * cos_q;
      hs_q    <= hi_m1_q * sin_q;
      hc_q    <= hi_m1_q * cos_q;
      ls_q    <= lo_m1_q * sin_q;
      out_data_q.rotated_low  <= res_lo;
      out_data_q.rotated_high <= res_hi;
      out_data_q.saturated    <= sat_lo || sat_hi;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/rpe_checker.sv
module rpe_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input rpe_pkg::rpe_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input rpe_pkg::rpe_out_t out_data_o
);

  // held result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // input is refused only while a result beat waits
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("in_ready_o wrong");

  // the flag only with a clamped value
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      out_data_o.rotated_low == 32'sh7FFFFFFF || out_data_o.rotated_low == 32'sh80000000 ||
      out_data_o.rotated_high == 32'sh7FFFFFFF || out_data_o.rotated_high == 32'sh80000000)
    else $error("saturated set without clamped value");

  // no result out of reset
  a_rst: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result during reset");

endmodule

bind rotary_position_embedding_core rpe_checker u_rpe_checker (.*);

FILE: bench/tb_rotary_position_embedding_core.sv
`default_nettype none

// Testbench for rotary_position_embedding_core.
// A short table of directed beats runs first, then about 1600 random beats.
// Loads fill the frequency table, and rotates only read entries already
// loaded. Typed directed rotates are scored against their given result, all
// others against a bit-true angle/CORDIC/rounding predictor held in this module.
module tb_rotary_position_embedding_core;
  import rpe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom  = 1600;
  localparam int DrainWait  = 80;    // longer than the pipeline latency
  localparam int LongHold   = 300;   // receiver hold-off, fills the pipe

  // fold constants in Q3.30 / Q.32
  localparam longint unsigned RevQ32  = 64'd26986075409;
  localparam longint          HalfPi  = 64'sd1686629713;
  localparam longint          Pi      = 64'sd3373259426;
  localparam longint          TwoPi   = 64'sd6746518852;
  localparam longint          InvGain = 64'sh26DD3B6A;

  localparam longint AtanTab [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000};

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  rpe_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  rpe_out_t out_data_o;

  rotary_position_embedding_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // shadow of the frequency table, plus a written mask so rotates never read
  // an entry that was never loaded
  logic [31:0] freq_shadow [TableDepth];
  bit          freq_loaded [TableDepth];

  rpe_out_t rotated_q [$];
  int       errors = 0;
  int       n_beats = 0, n_loads = 0, n_rotates = 0, n_results = 0, n_sat = 0;
  int       hold_left = 0;
  bit       hold_req = 1'b0;
  bit       drained = 1'b0;

  function automatic longint clamp_sat(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // angle = p*f mod 2pi, round to Q3.30, fold to [-pi/2, pi/2], CORDIC,
  // then the two products rounded half up and clamped
  function automatic rpe_out_t rotate_pair(input logic [11:0] pos,
                                           input logic [31:0] freq,
                                           input logic signed [31:0] lo_in,
                                           input logic signed [31:0] hi_in);
    longint unsigned ang;
    longint z, x, y, xs, ys, c, s, lo, hi, r_lo, r_hi;
    bit neg, sat;
    rpe_out_t r;
    ang = longint'(pos) * longint'(freq);
    z   = longint'(((ang % RevQ32) + 64'd2) >> 2);
    neg = 1'b0;
    sat = 1'b0;
    if (z > Pi) z -= TwoPi;
    if (z > HalfPi) begin
      z -= Pi;
      neg = 1'b1;
    end else if (z < -HalfPi) begin
      z += Pi;
      neg = 1'b1;
    end
    x = InvGain;
    y = 0;
    for (int i = 0; i < CordicStages && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= AtanTab[i];
      end else begin
        x += ys; y -= xs; z += AtanTab[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
    lo = longint'(lo_in);
    hi = longint'(hi_in);
    r_lo = clamp_sat((lo * c - hi * s + (64'sd1 << 29)) >>> 30, sat);
    r_hi = clamp_sat((hi * c + lo * s + (64'sd1 << 29)) >>> 30, sat);
    r.rotated_low  = r_lo[31:0];
    r.rotated_high = r_hi[31:0];
    r.saturated    = sat;
    return r;
  endfunction

  // drive one beat from the falling edge and hold it until taken; the
  // expectation is queued at the edge that accepts it
  task automatic send_beat(input rpe_in_t b, input bit typed, input rpe_out_t want);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = b;
    do @(posedge clk_i); while (!in_ready_o);
    n_beats++;
    if (b.operation == OpLoad) begin
      freq_shadow[b.pair_index] = b.freq_value;
      freq_loaded[b.pair_index] = 1'b1;
      n_loads++;
    end else begin
      n_rotates++;
      rotated_q.push_back(typed ? want :
        rotate_pair(b.position, freq_shadow[b.pair_index], b.element_low,
                    b.element_high));
    end
  endtask

  task automatic idle_sender(input int cycles);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_freq();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'hFFFF_FFFF >> $urandom_range(0, 31);  // rope-like spread
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_elem();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [11:0] pick_pos();
    case ($urandom_range(0, 5))
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  // Receiver: stalls on a slowly changing pattern; a hold-off request makes
  // it refuse beats while hold_left, loaded from LongHold, counts down here.
  initial begin
    int mode, mode_left;
    mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else begin
        case (mode)
          0: out_ready_i = 1'b1;                       // free-running
          1: out_ready_i = ($urandom_range(0, 3) != 0);
          2: out_ready_i = $urandom_range(0, 1);
          default: out_ready_i = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Scoreboard: each result beat against the oldest expectation
  always @(posedge clk_i) begin
    rpe_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (rotated_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $time, out_data_o);
      end else begin
        want = rotated_q.pop_front();
        if (out_data_o.saturated) n_sat++;
        if (out_data_o.rotated_low !== want.rotated_low) begin
          errors++;
          $display("%0t: rotated_low expected %h got %h", $time,
                   want.rotated_low, out_data_o.rotated_low);
        end
        if (out_data_o.rotated_high !== want.rotated_high) begin
          errors++;
          $display("%0t: rotated_high expected %h got %h", $time,
                   want.rotated_high, out_data_o.rotated_high);
        end
        if (out_data_o.saturated !== want.saturated) begin
          errors++;
          $display("%0t: saturated expected %b got %b", $time,
                   want.saturated, out_data_o.saturated);
        end
      end
    end
  end

  // Directed table. Rows flagged typed carry a result that is plain by eye
  // (zero inputs give zero); the rest go through the predictor.
  typedef struct {
    rpe_in_t  beat;
    bit       typed;
    rpe_out_t want;
  } row_t;

  localparam rpe_out_t Zero = '0;

  row_t directed [] = '{
    // loads: zero, full-scale and a mid value, both index extremes
    '{'{OpLoad, 6'd0,  12'd0,   32'h0000_0000, 32'h0, 32'h0}, 0, Zero},
    '{'{OpLoad, 6'd63, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000}, 0, Zero},
    '{'{OpLoad, 6'd1,  12'd0,   32'h1000_0000, 32'h0, 32'h0}, 0, Zero},
    '{'{OpLoad, 6'd2,  12'd0,   32'h8000_0000, 32'h0, 32'h0}, 0, Zero},
    // zero pair rotates to zero whatever the angle
    '{'{OpRotate, 6'd0,  12'd0,   32'h0, 32'h0, 32'h0}, 1, Zero},
    '{'{OpRotate, 6'd63, 12'hFFF, 32'hDEAD_BEEF, 32'h0, 32'h0}, 1, Zero},
    // angle zero, unit and extreme elements
    '{'{OpRotate, 6'd0, 12'd5,   32'h0, 32'h0001_0000, 32'hFFFF_0000}, 0, Zero},
    '{'{OpRotate, 6'd0, 12'hFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000}, 0, Zero},
    '{'{OpRotate, 6'd0, 12'd1,   32'h0, 32'h8000_0000, 32'h8000_0000}, 0, Zero},
    // large angles, full wrap, saturation near 45 degrees
    '{'{OpRotate, 6'd63, 12'hFFF, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0, Zero},
    '{'{OpRotate, 6'd63, 12'd1,   32'h0, 32'h8000_0000, 32'h7FFF_FFFF}, 0, Zero},
    '{'{OpRotate, 6'd1,  12'd3,   32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0, Zero},
    '{'{OpRotate, 6'd2,  12'd7,   32'h0, 32'h0003_0000, 32'hFFFD_0000}, 0, Zero},
    '{'{OpRotate, 6'd2,  12'hFFF, 32'h0, 32'h8000_0000, 32'h0000_0001}, 0, Zero},
    // reload an entry, then use it straight away
    '{'{OpLoad,   6'd1, 12'd0,   32'h2000_0000, 32'h0, 32'h0}, 0, Zero},
    '{'{OpRotate, 6'd1, 12'd100, 32'h0, 32'h1234_5678, 32'h8765_4321}, 0, Zero}
  };

  initial begin
    rpe_in_t b;
    int      burst, idx;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[k]) send_beat(directed[k].beat, directed[k].typed, directed[k].want);

    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < NumRandom; k++, n++) begin
        b = '0;
        b.operation  = ($urandom_range(0, 6) == 0) ? OpLoad : OpRotate;
        b.pair_index = 6'($urandom);
        b.position   = pick_pos();
        b.freq_value = $urandom;
        b.element_low  = pick_elem();
        b.element_high = pick_elem();
        if (b.operation == OpLoad) begin
          b.freq_value = pick_freq();
        end else if (!freq_loaded[b.pair_index]) begin
          // steer to a loaded entry, or load this one first
          idx = $urandom_range(0, TableDepth - 1);
          if (freq_loaded[idx]) b.pair_index = 6'(idx);
          else begin
            b.operation  = OpLoad;
            b.freq_value = pick_freq();
          end
        end
        send_beat(b, 0, Zero);
        if (n == 400) hold_req = 1'b1;   // long receiver hold while we keep sending
      end
      if (n >= 900 && !drained) begin
        // sender waits until the pipe has fully drained
        drained = 1'b1;
        @(negedge clk_i);
        in_valid_i = 1'b0;
        while (rotated_q.size() != 0) @(posedge clk_i);
      end
      idle_sender($urandom_range(1, 3) == 1 ? 1 : $urandom_range(1, 12));
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (rotated_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (rotated_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, rotated_q.size());
    end

    $display("Sent %0d beats (%0d table loads, %0d rotates); %0d results checked,",
             n_beats, n_loads, n_rotates, n_results);
    $display("%0d of them saturated, with random stalls on both sides.", n_sat);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
